@@ sv/pss_pkg.sv @@
// ----------------------------------------------------------------------------
// pss_pkg: shared definitions of the pattern step sequencer
// Field widths, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package pss_pkg;

	localparam int MAX_STEPS = 16;
	localparam int POS_W     = $clog2(MAX_STEPS);

	localparam int LEN_W   = 5;
	localparam int NOTE_W  = 4;
	localparam int CNT_W   = 16;
	localparam int VALS_W  = 64;
	localparam int MASK_W  = 16;

	localparam int APB_DW    = 64;
	localparam int APB_AW    = 5;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_LENGTH = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_VALUES = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_NOTES  = 2'd2;

	localparam logic [LEN_W-1:0]  RST_LENGTH = 5'd3;
	localparam logic [VALS_W-1:0] RST_VALUES = '0;
	localparam logic [MASK_W-1:0] RST_NOTES  = 16'h0007;

	typedef struct packed {
		logic [LEN_W-1:0]  pattern_length;
		logic [VALS_W-1:0] slot_values;
		logic [MASK_W-1:0] slot_is_note;
	} cfg_t;

endpackage

@@ sv/pss_if.sv @@
// ----------------------------------------------------------------------------
// pss_if: stream channels of the pattern step sequencer
// Step channel in, result channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pss_in_if;
	logic valid;
	logic ready;
	logic step_tick;

	modport source(output valid, output step_tick, input ready);
	modport sink(input valid, input step_tick, output ready);
endinterface

interface pss_out_if;
	import pss_pkg::*;

	logic              valid;
	logic              ready;
	logic              event_tick;
	logic [NOTE_W-1:0] note_value;
	logic              cycle_tick;
	logic [CNT_W-1:0]  cycle_count;
	logic [LEN_W-1:0]  event_length;

	modport source(output valid, output event_tick, output note_value, output cycle_tick,
		output cycle_count, output event_length, input ready);
	modport sink(input valid, input event_tick, input note_value, input cycle_tick,
		input cycle_count, input event_length, output ready);
endinterface

@@ sv/pattern_step_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// pattern_step_sequencer_top: pattern step sequencer
// Steps through a configured pattern of note and rest slots.
// ----------------------------------------------------------------------------
// Usage:
//   steps   - one transfer per evaluation; step_tick 1 advances one slot,
//             0 only reports the held state.
//   results - one transfer per step transfer: event and cycle ticks, the
//             latest note value and length, and the pattern cycle count.
//   APB     - pattern length (0x00), slot values (0x08), note mask (0x10);
//             write only while no step is in flight.
// A step transfer goes through the input register into the result register.
// One step is accepted every cycle while results are taken: the evaluation
// is a single registered pass (one increment, one compare and a priority
// search over the note mask) between the input and the result register.
// Reset clears the position, cycle count and held note, and loads length 3,
// slot values 0 and note mask 7. When the receiver stalls the result holds
// and steps keep being taken until the input register is also full.
// ----------------------------------------------------------------------------
module pattern_step_sequencer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	pss_in_if.sink                      steps,
	pss_out_if.source                   results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pss_pkg::APB_AW-1:0]  paddr,
	input  logic [pss_pkg::APB_DW-1:0]  pwdata,
	output logic [pss_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import pss_pkg::*;

	cfg_t cfg;

	pss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pss_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.steps   (steps),
		.results (results)
	);

`ifndef NO_ASSERTIONS
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!results.valid |-> steps.ready)
		else $error("step channel stalled with an empty result register");

	a_result_follows_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results.valid) |-> $past(steps.valid && steps.ready, 2))
		else $error("result appeared without a step transfer two cycles before");

	a_event_length: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.event_tick |->
			results.event_length != '0 && results.event_length <= LEN_W'(MAX_STEPS))
		else $error("note event with an impossible length");
`endif

endmodule

@@ sv/pss_cfg.sv @@
// ----------------------------------------------------------------------------
// pss_cfg: configuration registers
// APB-style register file holding pattern length, slot values and note mask.
// ----------------------------------------------------------------------------
module pss_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pss_pkg::APB_AW-1:0]  paddr,
	input  logic [pss_pkg::APB_DW-1:0]  pwdata,
	output logic [pss_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output pss_pkg::cfg_t               cfg
);
	import pss_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	// registers sit on 8-byte boundaries
	assign idx    = paddr[APB_AW-1:APB_AW-REG_IDX_W];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_length <= RST_LENGTH;
			cfg_q.slot_values    <= RST_VALUES;
			cfg_q.slot_is_note   <= RST_NOTES;
		end else if (wr_en) begin
			case (idx)
				REG_LENGTH: cfg_q.pattern_length <= pwdata[LEN_W-1:0];
				REG_VALUES: cfg_q.slot_values    <= pwdata[VALS_W-1:0];
				REG_NOTES:  cfg_q.slot_is_note   <= pwdata[MASK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_LENGTH: prdata = APB_DW'(cfg_q.pattern_length);
			REG_VALUES: prdata = APB_DW'(cfg_q.slot_values);
			REG_NOTES:  prdata = APB_DW'(cfg_q.slot_is_note);
			default:    prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

@@ sv/pss_seq.sv @@
// ----------------------------------------------------------------------------
// pss_seq: sequencer datapath
// Input register, one-pass step evaluation, sequencer state and result register.
// ----------------------------------------------------------------------------
module pss_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  pss_pkg::cfg_t cfg,
	pss_in_if.sink        steps,
	pss_out_if.source     results
);
	import pss_pkg::*;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_STEPS);

	// input stage
	logic v_s1;
	logic step_s1;
	logic adv;

	// sequencer state
	logic              started_q;
	logic [POS_W-1:0]  position_q;
	logic [CNT_W-1:0]  cycles_q;
	logic [NOTE_W-1:0] held_note_q;
	logic [LEN_W-1:0]  held_len_q;

	// result register
	logic              out_v_q;
	logic              event_q;
	logic [NOTE_W-1:0] note_q;
	logic              wrap_q;
	logic [CNT_W-1:0]  count_q;
	logic [LEN_W-1:0]  evlen_q;

	// evaluation
	logic [LEN_W-1:0]     len_c;
	logic [LEN_W-1:0]     nxt_raw;
	logic                 wrap_c;
	logic [POS_W-1:0]     new_pos;
	logic [MAX_STEPS-1:0] nmask;
	logic [NOTE_W-1:0]    vals [MAX_STEPS];
	logic [LEN_W-1:0]     end_idx;
	logic [LEN_W-1:0]     dur;

	logic              started_d;
	logic [POS_W-1:0]  position_d;
	logic [CNT_W-1:0]  cycles_d;
	logic [NOTE_W-1:0] held_note_d;
	logic [LEN_W-1:0]  held_len_d;
	logic              event_d;
	logic              wrap_d;

	assign adv          = !out_v_q || results.ready;
	assign steps.ready  = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (steps.ready) begin
			v_s1 <= steps.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (steps.valid && steps.ready) begin
			step_s1 <= steps.step_tick;
		end
	end

	assign nmask = cfg.slot_is_note[MAX_STEPS-1:0];

	always_comb begin
		for (int k = 0; k < MAX_STEPS; k++) begin
			vals[k] = cfg.slot_values[k*NOTE_W +: NOTE_W];
		end
	end

	assign len_c   = (cfg.pattern_length > MAX_LEN) ? MAX_LEN : cfg.pattern_length;
	assign nxt_raw = started_q ? (LEN_W'(position_q) + LEN_W'(1)) : '0;
	assign wrap_c  = (nxt_raw >= len_c);
	assign new_pos = wrap_c ? '0 : nxt_raw[POS_W-1:0];

	// first note after the new slot, or the pattern end if only rests follow
	always_comb begin
		end_idx = len_c;
		for (int k = MAX_STEPS - 1; k >= 0; k--) begin
			if (nmask[k] && (LEN_W'(k) > LEN_W'(new_pos)) && (LEN_W'(k) < len_c)) begin
				end_idx = LEN_W'(k);
			end
		end
	end

	assign dur = end_idx - LEN_W'(new_pos);

	always_comb begin
		started_d   = started_q;
		position_d  = position_q;
		cycles_d    = cycles_q;
		held_note_d = held_note_q;
		held_len_d  = held_len_q;
		event_d     = 1'b0;
		wrap_d      = 1'b0;
		if (len_c == '0) begin
			// empty pattern: clear note and cycle count, length 1, ignore the step
			held_note_d = '0;
			cycles_d    = '0;
			held_len_d  = LEN_W'(1);
		end else if (step_s1) begin
			started_d  = 1'b1;
			position_d = new_pos;
			wrap_d     = wrap_c;
			if (wrap_c) begin
				cycles_d = cycles_q + CNT_W'(1);
			end
			if (nmask[new_pos]) begin
				held_len_d  = dur;
				held_note_d = vals[new_pos];
				event_d     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			position_q  <= '0;
			cycles_q    <= '0;
			held_note_q <= '0;
			held_len_q  <= '0;
			out_v_q     <= 1'b0;
		end else if (v_s1 && adv) begin
			started_q   <= started_d;
			position_q  <= position_d;
			cycles_q    <= cycles_d;
			held_note_q <= held_note_d;
			held_len_q  <= held_len_d;
			out_v_q     <= 1'b1;
		end else if (results.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv) begin
			event_q <= event_d;
			note_q  <= held_note_d;
			wrap_q  <= wrap_d;
			count_q <= cycles_d;
			evlen_q <= held_len_d;
		end
	end

	assign results.valid        = out_v_q;
	assign results.event_tick   = event_q;
	assign results.note_value   = note_q;
	assign results.cycle_tick   = wrap_q;
	assign results.cycle_count  = count_q;
	assign results.event_length = evlen_q;

endmodule
